>>> hdl/generational_handle_allocator_assert.svh
// ----------------------------------------------------------------------------
// Generational handle allocator assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GHA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/gha_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Widths, codes and transaction types shared by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

   localparam int CAPACITY = 1024;
   localparam int GEN_BITS = 12;
   localparam int IDX_W    = 10;
   localparam int CNT_W    = 11;

   localparam logic [CNT_W-1:0] CAPACITY_CNT = CNT_W'(CAPACITY);

   localparam logic [1:0] OP_CREATE  = 2'd0;
   localparam logic [1:0] OP_DESTROY = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [IDX_W-1:0]    handle_index;
      logic [GEN_BITS-1:0] handle_generation;
   } gha_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]    new_index;
      logic [GEN_BITS-1:0] new_generation;
      logic [1:0]          status;
      logic [CNT_W-1:0]    live_count;
   } gha_rsp_type;

   typedef struct packed {
      logic                live;
      logic [GEN_BITS-1:0] generation;
   } gha_slot_type;

   typedef struct packed {
      logic [IDX_W-1:0]    slot_index;
      logic [GEN_BITS-1:0] generation;
   } gha_entry_type;

   typedef struct packed {
      logic             gen_we;
      logic [IDX_W-1:0] gen_addr;
      gha_slot_type     gen_data;
      logic             stk_we;
      logic [IDX_W-1:0] stk_addr;
      gha_entry_type    stk_data;
   } gha_mem_wr_type;

   typedef struct packed {
      logic [CNT_W-1:0] slots_used;
      logic [CNT_W-1:0] free_depth;
      logic [CNT_W-1:0] live_total;
   } gha_count_type;

endpackage

`default_nettype wire

>>> hdl/gha_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// Registered read; a read of the address written in the same cycle returns
// the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/gha_engine.sv
// ----------------------------------------------------------------------------
// Generational handle allocator engine
// Decides one operation from the slot and free stack entries read for it,
// and holds the slot, free stack and live counters.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   commit,
   input  wire gha_pkg::gha_req_type   s1_req,
   input  wire gha_pkg::gha_slot_type  gen_rdata,
   input  wire gha_pkg::gha_entry_type stk_rdata,
   output      gha_pkg::gha_mem_wr_type wr,
   output      gha_pkg::gha_rsp_type   rsp,
   output      logic [gha_pkg::CNT_W-1:0] depth_next,
   output      gha_pkg::gha_count_type cnt
);

   logic [gha_pkg::CNT_W-1:0]    slots_used_ff, slots_used_in;
   logic [gha_pkg::CNT_W-1:0]    free_depth_ff, free_depth_in;
   logic [gha_pkg::CNT_W-1:0]    live_total_ff, live_total_in;
   logic [gha_pkg::GEN_BITS-1:0] gen_next;
   logic                         alive;

   assign gen_next = gen_rdata.generation + gha_pkg::GEN_BITS'(1);
   assign alive    = ({1'b0, s1_req.handle_index} < slots_used_ff) && gen_rdata.live &&
                     (gen_rdata.generation == s1_req.handle_generation);

   always_comb begin
      slots_used_in = slots_used_ff;
      free_depth_in = free_depth_ff;
      live_total_in = live_total_ff;
      wr            = '0;
      rsp           = '0;
      rsp.status    = gha_pkg::ST_BAD;
      unique case (s1_req.opcode)
         gha_pkg::OP_CREATE: begin
            if (free_depth_ff != '0) begin
               free_depth_in       = free_depth_ff - gha_pkg::CNT_W'(1);
               live_total_in       = live_total_ff + gha_pkg::CNT_W'(1);
               wr.gen_we           = 1'b1;
               wr.gen_addr         = stk_rdata.slot_index;
               wr.gen_data.live    = 1'b1;
               wr.gen_data.generation = stk_rdata.generation;
               rsp.new_index       = stk_rdata.slot_index;
               rsp.new_generation  = stk_rdata.generation;
               rsp.status          = gha_pkg::ST_OK;
            end else if (slots_used_ff != gha_pkg::CAPACITY_CNT) begin
               slots_used_in       = slots_used_ff + gha_pkg::CNT_W'(1);
               live_total_in       = live_total_ff + gha_pkg::CNT_W'(1);
               wr.gen_we           = 1'b1;
               wr.gen_addr         = slots_used_ff[gha_pkg::IDX_W-1:0];
               wr.gen_data.live    = 1'b1;
               rsp.new_index       = slots_used_ff[gha_pkg::IDX_W-1:0];
               rsp.status          = gha_pkg::ST_OK;
            end else begin
               rsp.status          = gha_pkg::ST_FULL;
            end
         end
         gha_pkg::OP_DESTROY: begin
            if (alive && (free_depth_ff != gha_pkg::CAPACITY_CNT)) begin
               free_depth_in       = free_depth_ff + gha_pkg::CNT_W'(1);
               if (live_total_ff != '0) begin
                  live_total_in    = live_total_ff - gha_pkg::CNT_W'(1);
               end
               wr.gen_we           = 1'b1;
               wr.gen_addr         = s1_req.handle_index;
               wr.gen_data.generation = gen_next;
               wr.stk_we           = 1'b1;
               wr.stk_addr         = free_depth_ff[gha_pkg::IDX_W-1:0];
               wr.stk_data.slot_index = s1_req.handle_index;
               wr.stk_data.generation = gen_next;
               rsp.status          = gha_pkg::ST_OK;
            end
         end
         gha_pkg::OP_QUERY: begin
            if (alive) begin
               rsp.status = gha_pkg::ST_OK;
            end
         end
         default: begin
         end
      endcase
      rsp.live_count = live_total_in;
      if (!commit) begin
         wr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_used_ff <= '0;
         free_depth_ff <= '0;
         live_total_ff <= '0;
      end else if (commit) begin
         slots_used_ff <= slots_used_in;
         free_depth_ff <= free_depth_in;
         live_total_ff <= live_total_in;
      end
   end

   assign depth_next     = commit ? free_depth_in : free_depth_ff;
   assign cnt.slots_used = slots_used_ff;
   assign cnt.free_depth = free_depth_ff;
   assign cnt.live_total = live_total_ff;

endmodule

`default_nettype wire

>>> hdl/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// Generational handle allocator
// Creates, destroys and checks handles made of a slot index and generation.
//
// Request channel req_valid/req_ready/req_data carries an opcode and, for
// destroy and query, a handle. Every request gives exactly one response on
// rsp_valid/rsp_ready/rsp_data, in request order, with the created handle,
// a status and the live handle count after the operation.
// Flow: an accepted request is registered into stage s1 with its slot and
// free stack reads, is decided there, and its response is registered in
// the output register; a stall on rsp_ready holds the request in s1.
// Throughput: one transaction per cycle while the receiver takes responses;
// the slot table and free stack are read at acceptance and written when the
// operation is decided, with write-to-read forwarding between consecutive
// transactions. Reset clears the slot, free stack and live counters; no
// clearing pass is needed, so requests are taken as soon as reset ends.
// When the receiver stalls, one response waits in the output register and
// one further request is still accepted and held; then req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_allocator (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire gha_pkg::gha_req_type req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      gha_pkg::gha_rsp_type rsp_data
);

   logic                      s1_valid_ff, s1_valid_in;
   gha_pkg::gha_req_type      s1_req_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   gha_pkg::gha_rsp_type      rsp_data_ff;
   logic                      req_accept;
   logic                      s1_advance;
   gha_pkg::gha_slot_type     gen_rdata;
   gha_pkg::gha_entry_type    stk_rdata;
   gha_pkg::gha_mem_wr_type   wr;
   gha_pkg::gha_rsp_type      eng_rsp;
   gha_pkg::gha_count_type    cnt;
   logic [gha_pkg::CNT_W-1:0] depth_next;
   logic [gha_pkg::CNT_W-1:0] pop_pos;
   logic [gha_pkg::CNT_W:0]   occupancy;
   logic [gha_pkg::CNT_W:0]   used_wide;
   logic                      full_seen;
   logic                      table_exhausted;
   logic                      destroy_ok;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;
   assign pop_pos    = depth_next - gha_pkg::CNT_W'(1);

   gha_ram #(
      .WIDTH($bits(gha_pkg::gha_slot_type)),
      .DEPTH(gha_pkg::CAPACITY)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (wr.gen_we),
      .wr_addr (wr.gen_addr),
      .wr_data (wr.gen_data),
      .rd_en   (req_accept),
      .rd_addr (req_data.handle_index),
      .rd_data (gen_rdata)
   );

   gha_ram #(
      .WIDTH($bits(gha_pkg::gha_entry_type)),
      .DEPTH(gha_pkg::CAPACITY)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr.stk_we),
      .wr_addr (wr.stk_addr),
      .wr_data (wr.stk_data),
      .rd_en   (req_accept),
      .rd_addr (pop_pos[gha_pkg::IDX_W-1:0]),
      .rd_data (stk_rdata)
   );

   gha_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .commit     (s1_advance),
      .s1_req     (s1_req_ff),
      .gen_rdata  (gen_rdata),
      .stk_rdata  (stk_rdata),
      .wr         (wr),
      .rsp        (eng_rsp),
      .depth_next (depth_next),
      .cnt        (cnt)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
      if (s1_advance) begin
         rsp_data_ff <= eng_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign occupancy       = (gha_pkg::CNT_W+1)'(cnt.live_total) +
                            (gha_pkg::CNT_W+1)'(cnt.free_depth);
   assign used_wide       = (gha_pkg::CNT_W+1)'(cnt.slots_used);
   assign full_seen       = s1_advance && (eng_rsp.status == gha_pkg::ST_FULL);
   assign table_exhausted = (cnt.slots_used == gha_pkg::CAPACITY_CNT) &&
                            (cnt.free_depth == '0);
   assign destroy_ok      = s1_advance && (s1_req_ff.opcode == gha_pkg::OP_DESTROY) &&
                            (eng_rsp.status == gha_pkg::ST_OK);

`include "generational_handle_allocator_assert.svh"

   `GHA_ASSERT_SAME(a_slots_accounted, 1'b1, occupancy == used_wide, "live plus free slots differ from slots used")
   `GHA_ASSERT_SAME(a_full_only_when_exhausted, full_seen, table_exhausted, "full status while slots remain")
   `GHA_ASSERT_NEXT(a_destroy_pushes, destroy_ok, cnt.free_depth == $past(cnt.free_depth) + gha_pkg::CNT_W'(1), "destroy did not push the free stack")

endmodule

`default_nettype wire
